/* hdl/dbes_pkg.sv */
`default_nettype none

package dbes_pkg;

    // field and state widths
    localparam int PHASE_W  = 32;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int AMP_W    = 18;
    localparam int ROM_W    = 28;
    localparam int PROD_W   = AMP_W + ROM_W;
    localparam int DAC_W    = 16;
    localparam int SAMPLE_W = 12;
    localparam int AMP_EXT_W = AMP_W + 2;

    // fix15 envelope scaling: two 15-bit shifts in a row
    localparam int FRAC_SHIFT = 30;

    // sine table scale, fix15 of 2047
    localparam real SINE_SCALE = 32768.0 * 2047.0;
    localparam real SINE_SPAN  = 6.283;

    // output constants
    localparam logic [DAC_W-1:0] DAC_CMD   = 16'hB000;
    localparam logic [DAC_W-1:0] MID_LEVEL = 16'd2048;

    // envelope saturation limits
    localparam logic signed [AMP_EXT_W-1:0] AMP_MAX = 20'sd131071;
    localparam logic signed [AMP_EXT_W-1:0] AMP_MIN = -20'sd131072;

    // register reset values
    localparam logic [PHASE_W-1:0] RST_PHASE_INC   = 32'd42949672;
    localparam logic [CFG_W-1:0]   RST_ATTACK_STEP = 16'd163;
    localparam logic [CFG_W-1:0]   RST_DECAY_STEP  = 16'd163;
    localparam logic [CFG_W-1:0]   RST_ATTACK_LEN  = 16'd200;
    localparam logic [CFG_W-1:0]   RST_DECAY_LEN   = 16'd200;
    localparam logic [CFG_W-1:0]   RST_BEEP_LEN    = 16'd10400;
    localparam logic [CFG_W-1:0]   RST_SILENCE_LEN = 16'd40000;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_INC   = 3'd0,
        CFG_ATTACK_STEP = 3'd1,
        CFG_DECAY_STEP  = 3'd2,
        CFG_ATTACK_LEN  = 3'd3,
        CFG_DECAY_LEN   = 3'd4,
        CFG_BEEP_LEN    = 3'd5,
        CFG_SILENCE_LEN = 3'd6
    } cfg_index_t;

endpackage

`default_nettype wire

/* hdl/dbes_channels.sv */
`default_nettype none

// tick input channel
interface dbes_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// sample output channel
interface dbes_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] dac_word;
    logic [11:0] sample_value;

    modport source (output valid, output dac_word, output sample_value, input ready);
    modport sink (input valid, input dac_word, input sample_value, output ready);
endinterface

`default_nettype wire

/* hdl/dbes_sine_rom.sv */
`default_nettype none

module dbes_sine_rom
    import dbes_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  wire logic                    clk,
    input  wire logic                    rd_en,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic signed [ROM_W-1:0]      rd_data
);

    typedef logic signed [ROM_W-1:0] rom_array_t [TABLE_DEPTH];

    // angle step between table entries
    localparam real SINE_STEP = SINE_SPAN / real'(TABLE_DEPTH);

    // fix15 sine entries, truncated toward zero
    function automatic rom_array_t build_rom();
        rom_array_t r;
        real        s;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            s    = $sin(real'(i) * SINE_STEP);
            r[i] = ROM_W'($rtoi(SINE_SCALE * s));
        end
        return r;
    endfunction

    localparam rom_array_t SINE_TABLE = build_rom();

    logic signed [ROM_W-1:0] rd_data_reg;

    // registered read, held while the stage stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= SINE_TABLE[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/dds_beep_envelope_synth.sv */
// Beep tone generator: a phase accumulator drives a sine table whose output
// is shaped by a linear attack/decay envelope, in repeating beep and silence
// phases.
// ticks: one transfer per sample period. A tick in the beep phase yields one
//   transfer on samples (dac_word = 0xB000 | sample, sample_value = 12-bit
//   offset-binary sample); a tick in the silence phase yields none.
// cfg_we/cfg_index/cfg_data: register writes, taken on any clock edge with
//   cfg_we high, index 0..6 = phase increment, attack step, decay step,
//   attack length, decay length, beep length, silence length. Write only
//   while no sample is in flight.
// Path: a beep tick's sample is registered in the table read, multiply and
//   output registers in that order before it is valid on samples.
// Throughput: one tick per cycle while not stalled; envelope and phase state
//   update in the cycle of the transfer, the rest is a 3-stage pipeline.
// Stall: each stage advances when the one after it is empty or moving, so
//   bubbles collapse and ticks keep being taken until all three stages hold
//   a sample; ticks.ready then follows samples.ready.
// Reset: registers return to their default values, phase, envelope and tick
//   count clear, the beep phase comes first and the pipeline empties.
`default_nettype none

module dds_beep_envelope_synth
    import dbes_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    dbes_tick_if.sink                   ticks,
    dbes_sample_if.source               samples,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SCALE_W = $clog2(TABLE_DEPTH + 1);
    localparam int IXP_W   = PHASE_W + SCALE_W;

    // configuration registers
    logic [PHASE_W-1:0] phase_inc_reg;
    logic [CFG_W-1:0]   attack_step_reg;
    logic [CFG_W-1:0]   decay_step_reg;
    logic [CFG_W-1:0]   attack_len_reg;
    logic [CFG_W-1:0]   decay_len_reg;
    logic [CFG_W-1:0]   beep_len_reg;
    logic [CFG_W-1:0]   silence_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg   <= RST_PHASE_INC;
            attack_step_reg <= RST_ATTACK_STEP;
            decay_step_reg  <= RST_DECAY_STEP;
            attack_len_reg  <= RST_ATTACK_LEN;
            decay_len_reg   <= RST_DECAY_LEN;
            beep_len_reg    <= RST_BEEP_LEN;
            silence_len_reg <= RST_SILENCE_LEN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_INC:   phase_inc_reg   <= cfg_data[PHASE_W-1:0];
                CFG_ATTACK_STEP: attack_step_reg <= cfg_data[CFG_W-1:0];
                CFG_DECAY_STEP:  decay_step_reg  <= cfg_data[CFG_W-1:0];
                CFG_ATTACK_LEN:  attack_len_reg  <= cfg_data[CFG_W-1:0];
                CFG_DECAY_LEN:   decay_len_reg   <= cfg_data[CFG_W-1:0];
                CFG_BEEP_LEN:    beep_len_reg    <= cfg_data[CFG_W-1:0];
                CFG_SILENCE_LEN: silence_len_reg <= cfg_data[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // pipeline flow control
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_adv, s2_adv, s3_adv;

    assign s3_adv      = !s3_valid_reg || samples.ready;
    assign s2_adv      = !s2_valid_reg || s3_adv;
    assign s1_adv      = !s1_valid_reg || s2_adv;
    assign ticks.ready = s1_adv;

    logic tick_xfer;
    assign tick_xfer = ticks.valid && ticks.ready && ticks.tick;

    // tone and envelope state
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic signed [AMP_W-1:0] amp_reg, amp_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    silent_reg, silent_next;
    logic                    beep_xfer;

    logic [COUNT_W-1:0]          count_inc;
    logic [PHASE_W-1:0]          phase_sum;
    logic [IXP_W-1:0]            idx_prod;
    logic [IDX_W-1:0]            rom_idx;
    logic signed [AMP_EXT_W-1:0] amp_wide;
    logic signed [AMP_EXT_W-1:0] amp_up;
    logic signed [AMP_EXT_W-1:0] amp_down;
    logic signed [CFG_W+1:0]     decay_bound;
    logic                        in_attack;
    logic                        in_decay;

    assign count_inc   = count_reg + 1'b1;
    assign phase_sum   = phase_reg + phase_inc_reg;
    assign idx_prod    = IXP_W'(phase_sum) * IXP_W'(TABLE_DEPTH);
    assign rom_idx     = idx_prod[PHASE_W +: IDX_W];
    assign amp_wide    = {{2{amp_reg[AMP_W-1]}}, amp_reg};
    assign amp_up      = amp_wide + $signed({4'b0, attack_step_reg});
    assign amp_down    = amp_wide - $signed({4'b0, decay_step_reg});
    assign decay_bound = $signed({2'b0, beep_len_reg}) - $signed({2'b0, decay_len_reg});
    assign in_attack   = count_reg < attack_len_reg;
    assign in_decay    = $signed({2'b0, count_reg}) > decay_bound;
    assign beep_xfer   = tick_xfer && !silent_reg;

    // per-tick state update
    always_comb
    begin
        phase_next  = phase_reg;
        amp_next    = amp_reg;
        count_next  = count_reg;
        silent_next = silent_reg;
        if (tick_xfer)
        begin
            count_next = count_inc;
            if (silent_reg)
            begin
                if (count_inc == silence_len_reg)
                begin
                    amp_next    = '0;
                    silent_next = 1'b0;
                    count_next  = '0;
                end
            end
            else
            begin
                phase_next = phase_sum;
                priority if (in_attack)
                begin
                    priority if (amp_up > AMP_MAX)
                        amp_next = AMP_MAX[AMP_W-1:0];
                    else
                        amp_next = amp_up[AMP_W-1:0];
                end
                else if (in_decay)
                begin
                    priority if (amp_down < AMP_MIN)
                        amp_next = AMP_MIN[AMP_W-1:0];
                    else
                        amp_next = amp_down[AMP_W-1:0];
                end
                else
                begin
                    amp_next = amp_reg;
                end
                if (count_inc == beep_len_reg)
                begin
                    silent_next = 1'b1;
                    count_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            amp_reg    <= '0;
            count_reg  <= '0;
            silent_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            amp_reg    <= amp_next;
            count_reg  <= count_next;
            silent_reg <= silent_next;
        end
    end

    // stage 1: sine table read, amplitude before this tick
    logic signed [ROM_W-1:0] rom_data;
    logic signed [AMP_W-1:0] s1_amp_reg;

    dbes_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (s1_adv),
        .rd_addr (rom_idx),
        .rd_data (rom_data)
    );

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_amp_reg <= amp_reg;
        end
    end

    // stage 2: envelope multiply
    logic signed [PROD_W-1:0] s2_prod_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_prod_reg <= s1_amp_reg * rom_data;
        end
    end

    // stage 3: shift, offset and command bits
    logic [DAC_W-1:0]    level;
    logic [DAC_W-1:0]    s3_dac_reg;
    logic [SAMPLE_W-1:0] s3_sample_reg;

    assign level = s2_prod_reg[FRAC_SHIFT +: DAC_W] + MID_LEVEL;

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_dac_reg    <= DAC_CMD | level;
            s3_sample_reg <= level[SAMPLE_W-1:0];
        end
    end

    // stage valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        if (s1_adv)
            s1_valid_next = beep_xfer;
        if (s2_adv)
            s2_valid_next = s1_valid_reg;
        if (s3_adv)
            s3_valid_next = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    assign samples.valid        = s3_valid_reg;
    assign samples.dac_word     = s3_dac_reg;
    assign samples.sample_value = s3_sample_reg;

endmodule

`default_nettype wire
